// ===== rtl/core/dual_axis_light_tracker_step_top_macros.svh =====
// Assertion macros for the dual-axis light tracker.
// Expect clk and arst_n in the scope of each use.
`ifndef DUAL_AXIS_LIGHT_TRACKER_STEP_TOP_MACROS_SVH
`define DUAL_AXIS_LIGHT_TRACKER_STEP_TOP_MACROS_SVH

// Same-cycle implication.
`define DALT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DALT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/dalt_pkg.sv =====
// Shared types and constants for the dual-axis light tracker.
// No dependencies.
package dalt_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int ANGLE_BITS = 9;
	localparam int TOL_BITS = 7;
	localparam int BAND_BITS = 9;
	localparam int WIDE_BITS = (SAMPLE_BITS > BAND_BITS) ? SAMPLE_BITS : BAND_BITS;
	localparam int RECIP_BITS = 15;
	localparam int RECIP_SHIFT = 16;
	localparam int CFG_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 32;

	localparam logic [BAND_BITS-1:0] MEAN_BAND_TOP = 9'd300;
	localparam logic [BAND_BITS-1:0] MEAN_OFFSET = 9'd10;
	// close to 2^16 * 19/58, and ceil(2^16 * 5/29)
	localparam logic [RECIP_BITS-1:0] TOL_RECIP = 15'd21470;
	localparam logic [RECIP_BITS-1:0] DLY_RECIP = 15'd11300;

	localparam logic [TOL_BITS-1:0] TOL_BASE = 7'd5;
	localparam logic [TOL_BITS-1:0] DLY_BASE = 7'd100;
	localparam logic [TOL_BITS-1:0] TOL_DEFAULT = 7'd50;
	localparam logic [TOL_BITS-1:0] DLY_DEFAULT = 7'd10;

	localparam logic [ANGLE_BITS-1:0] VERT_POS_RESET = 9'd95;
	localparam logic [ANGLE_BITS-1:0] HORIZ_POS_RESET = 9'd90;
	localparam logic [ANGLE_BITS-1:0] LIM_LOW_RESET = 9'd0;
	localparam logic [ANGLE_BITS-1:0] LIM_HIGH_RESET = 9'd270;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [ANGLE_BITS-1:0] angle_t;
	typedef logic [TOL_BITS-1:0] tol_t;

	typedef struct packed {
		angle_t low;
		angle_t high;
	} axis_lim_t;

	typedef struct packed {
		angle_t pos;
		logic moved;
	} axis_res_t;

	typedef enum logic [1:0] {
		REG_VERT_LOW,
		REG_VERT_HIGH,
		REG_HORIZ_LOW,
		REG_HORIZ_HIGH
	} reg_idx_t;

endpackage

// ===== rtl/core/dalt_if.sv =====
// Valid/ready channel interfaces for the light tracker: sample words in, result words out.
// Depends on dalt_pkg.
interface dalt_in_if;
	import dalt_pkg::*;

	logic valid;
	logic ready;
	sample_t top_left;
	sample_t top_right;
	sample_t bottom_left;
	sample_t bottom_right;

	modport source (output valid, top_left, top_right, bottom_left, bottom_right,
		input ready);
	modport sink (input valid, top_left, top_right, bottom_left, bottom_right,
		output ready);
endinterface

interface dalt_out_if;
	import dalt_pkg::*;

	logic valid;
	logic ready;
	angle_t vert_angle;
	angle_t horiz_angle;
	logic vert_moved;
	logic horiz_moved;
	tol_t tolerance_used;
	tol_t settle_delay_ms;

	modport source (output valid, vert_angle, horiz_angle, vert_moved, horiz_moved,
		tolerance_used, settle_delay_ms, input ready);
	modport sink (input valid, vert_angle, horiz_angle, vert_moved, horiz_moved,
		tolerance_used, settle_delay_ms, output ready);
endinterface

// ===== rtl/core/dual_axis_light_tracker_step_top.sv =====
// Top level of the dual-axis light tracker: input stage, tolerance and delay, both axes, APB limits.
// Depends on dalt_pkg, dalt_if, dalt_axis and the macro header.
//
// Takes one quad of light samples per clock unless the result output is stalled and returns one
// result word per quad, in order, through the input register, then the result register;
// the update of the two angle registers, which each quad reads and writes before the next
// one, bounds the rate. The input stays ready while a finished result waits, as long as the
// input register is empty. The four angle limits sit at APB byte addresses 0, 4, 8 and 12;
// the user must write them only while the block is idle, which the block does not enforce.
module dual_axis_light_tracker_step_top (
	input  logic                               clk,
	input  logic                               arst_n,
	dalt_in_if.sink                            samples,
	dalt_out_if.source                         results,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [dalt_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [dalt_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [dalt_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                               pready
);
	import dalt_pkg::*;

	`include "dual_axis_light_tracker_step_top_macros.svh"

	angle_t vert_low_q;
	angle_t vert_high_q;
	angle_t horiz_low_q;
	angle_t horiz_high_q;
	angle_t vert_pos_q;
	angle_t horiz_pos_q;

	logic valid_s1;
	sample_t tl_s1;
	sample_t tr_s1;
	sample_t bl_s1;
	sample_t br_s1;

	logic valid_s2;
	angle_t vert_angle_s2;
	angle_t horiz_angle_s2;
	logic vert_moved_s2;
	logic horiz_moved_s2;
	tol_t tol_s2;
	tol_t dly_s2;

	logic advance_s1;
	logic fire_s1;
	logic wr_en;
	reg_idx_t wr_idx;

	logic [SAMPLE_BITS:0] sum_top;
	logic [SAMPLE_BITS:0] sum_bottom;
	logic [SAMPLE_BITS:0] sum_left;
	logic [SAMPLE_BITS:0] sum_right;
	sample_t avg_top;
	sample_t avg_bottom;
	sample_t avg_left;
	sample_t avg_right;
	logic [SAMPLE_BITS+1:0] sum_all;
	logic [WIDE_BITS-1:0] mean;
	logic in_band;
	logic below_offset;
	logic [BAND_BITS-1:0] offset_mag;
	logic [BAND_BITS+RECIP_BITS-1:0] tol_prod;
	logic [BAND_BITS+RECIP_BITS-1:0] dly_prod;
	tol_t tol_step;
	tol_t dly_step;
	tol_t tol;
	tol_t dly;

	axis_lim_t vert_lim;
	axis_lim_t horiz_lim;
	axis_res_t vert_res;
	axis_res_t horiz_res;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite & pready;
	assign wr_idx = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_low_q <= LIM_LOW_RESET;
			vert_high_q <= LIM_HIGH_RESET;
			horiz_low_q <= LIM_LOW_RESET;
			horiz_high_q <= LIM_HIGH_RESET;
		end else if (wr_en) begin
			case (wr_idx)
				REG_VERT_LOW: vert_low_q <= pwdata[ANGLE_BITS-1:0];
				REG_VERT_HIGH: vert_high_q <= pwdata[ANGLE_BITS-1:0];
				REG_HORIZ_LOW: horiz_low_q <= pwdata[ANGLE_BITS-1:0];
				REG_HORIZ_HIGH: horiz_high_q <= pwdata[ANGLE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (wr_idx)
			REG_VERT_LOW: prdata = APB_DATA_BITS'(vert_low_q);
			REG_VERT_HIGH: prdata = APB_DATA_BITS'(vert_high_q);
			REG_HORIZ_LOW: prdata = APB_DATA_BITS'(horiz_low_q);
			REG_HORIZ_HIGH: prdata = APB_DATA_BITS'(horiz_high_q);
			default: prdata = '0;
		endcase
	end

	assign advance_s1 = !valid_s2 || results.ready;
	assign fire_s1 = valid_s1 && advance_s1;
	assign samples.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			tl_s1 <= samples.top_left;
			tr_s1 <= samples.top_right;
			bl_s1 <= samples.bottom_left;
			br_s1 <= samples.bottom_right;
		end
	end

	assign sum_top = {1'b0, tl_s1} + {1'b0, tr_s1};
	assign sum_bottom = {1'b0, bl_s1} + {1'b0, br_s1};
	assign sum_left = {1'b0, tl_s1} + {1'b0, bl_s1};
	assign sum_right = {1'b0, tr_s1} + {1'b0, br_s1};
	assign avg_top = sum_top[SAMPLE_BITS:1];
	assign avg_bottom = sum_bottom[SAMPLE_BITS:1];
	assign avg_left = sum_left[SAMPLE_BITS:1];
	assign avg_right = sum_right[SAMPLE_BITS:1];
	assign sum_all = {2'b00, avg_top} + {2'b00, avg_bottom} + {2'b00, avg_left}
		+ {2'b00, avg_right};
	assign mean = WIDE_BITS'(sum_all[SAMPLE_BITS+1:2]);

	assign in_band = (mean != '0) && (mean < WIDE_BITS'(MEAN_BAND_TOP));
	assign below_offset = mean < WIDE_BITS'(MEAN_OFFSET);
	assign offset_mag = below_offset ? BAND_BITS'(WIDE_BITS'(MEAN_OFFSET) - mean)
		: BAND_BITS'(mean - WIDE_BITS'(MEAN_OFFSET));

	assign tol_prod = (BAND_BITS+RECIP_BITS)'(offset_mag)
		* (BAND_BITS+RECIP_BITS)'(TOL_RECIP);
	assign dly_prod = (BAND_BITS+RECIP_BITS)'(offset_mag)
		* (BAND_BITS+RECIP_BITS)'(DLY_RECIP);
	assign tol_step = tol_prod[RECIP_SHIFT+TOL_BITS-1:RECIP_SHIFT];
	assign dly_step = dly_prod[RECIP_SHIFT+TOL_BITS-1:RECIP_SHIFT];

	always_comb begin
		if (!in_band) begin
			tol = TOL_DEFAULT;
			dly = DLY_DEFAULT;
		end else if (below_offset) begin
			tol = TOL_BASE - tol_step;
			dly = DLY_BASE + dly_step;
		end else begin
			tol = TOL_BASE + tol_step;
			dly = DLY_BASE - dly_step;
		end
	end

	assign vert_lim = '{low: vert_low_q, high: vert_high_q};
	assign horiz_lim = '{low: horiz_low_q, high: horiz_high_q};

	dalt_axis u_vert (
		.up_side   (avg_top),
		.down_side (avg_bottom),
		.tol       (tol),
		.pos       (vert_pos_q),
		.lim       (vert_lim),
		.res       (vert_res)
	);

	dalt_axis u_horiz (
		.up_side   (avg_left),
		.down_side (avg_right),
		.tol       (tol),
		.pos       (horiz_pos_q),
		.lim       (horiz_lim),
		.res       (horiz_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_pos_q <= VERT_POS_RESET;
			horiz_pos_q <= HORIZ_POS_RESET;
		end else if (fire_s1) begin
			vert_pos_q <= vert_res.pos;
			horiz_pos_q <= horiz_res.pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			vert_angle_s2 <= vert_res.pos;
			horiz_angle_s2 <= horiz_res.pos;
			vert_moved_s2 <= vert_res.moved;
			horiz_moved_s2 <= horiz_res.moved;
			tol_s2 <= tol;
			dly_s2 <= dly;
		end
	end

	assign results.valid = valid_s2;
	assign results.vert_angle = vert_angle_s2;
	assign results.horiz_angle = horiz_angle_s2;
	assign results.vert_moved = vert_moved_s2;
	assign results.horiz_moved = horiz_moved_s2;
	assign results.tolerance_used = tol_s2;
	assign results.settle_delay_ms = dly_s2;

	`DALT_ASSERT_NEXT(a_pos_hold_idle, !fire_s1,
		$stable(vert_pos_q) && $stable(horiz_pos_q), "angle changed without a word")
	`DALT_ASSERT_NEXT(a_vert_hold_dead_band, fire_s1 && !vert_res.moved,
		vert_pos_q == $past(vert_pos_q), "vertical angle moved inside the dead band")
	`DALT_ASSERT_NEXT(a_vert_step_up, fire_s1 && vert_res.moved && (avg_top > avg_bottom),
		(vert_pos_q == $past(vert_high_q)) || (vert_pos_q == $past(vert_pos_q) + ANGLE_BITS'(1)),
		"vertical up step neither incremented nor clamped")
	`DALT_ASSERT_NOW(a_tol_range, valid_s1,
		(tol >= 7'd3) && (tol <= 7'd99), "tolerance out of range")
	`DALT_ASSERT_NOW(a_result_source, $rose(valid_s2),
		$past(fire_s1), "result appeared without a word from the input stage")

endmodule

// ===== rtl/core/dalt_axis.sv =====
// One axis step: dead-band test on the side difference and a clamped one-degree move.
// Depends on dalt_pkg.
module dalt_axis (
	input  dalt_pkg::sample_t   up_side,
	input  dalt_pkg::sample_t   down_side,
	input  dalt_pkg::tol_t      tol,
	input  dalt_pkg::angle_t    pos,
	input  dalt_pkg::axis_lim_t lim,
	output dalt_pkg::axis_res_t res
);
	import dalt_pkg::*;

	logic [SAMPLE_BITS:0] diff;
	logic [SAMPLE_BITS:0] diff_neg;
	sample_t mag;
	logic moved;

	assign diff = {1'b0, up_side} - {1'b0, down_side};
	assign diff_neg = {1'b0, down_side} - {1'b0, up_side};
	assign mag = diff[SAMPLE_BITS] ? diff_neg[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];
	assign moved = mag > {{(SAMPLE_BITS-TOL_BITS){1'b0}}, tol};

	always_comb begin
		res.moved = moved;
		res.pos = pos;
		if (moved) begin
			if (up_side > down_side) begin
				res.pos = (pos >= lim.high) ? lim.high : pos + ANGLE_BITS'(1);
			end else if (up_side < down_side) begin
				res.pos = (pos <= lim.low) ? lim.low : pos - ANGLE_BITS'(1);
			end
		end
	end

endmodule
